### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

### sv/iga_pkg.sv
// ---------------------------------------------------------------------------
// iga_pkg
// Widths, codes and controller/datapath interface types of the aggregator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package iga_pkg;

  localparam int GRP_W     = 12;
  localparam int ITV_W     = 12;
  localparam int VAL_W     = 32;
  localparam int TOT_W     = 64;
  localparam int IPG_W     = 13;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  // group * stride + intervention never exceeds 25 bits
  localparam int ADDR_W    = 25;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_IPG  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SQSUM = 2'd2;

  localparam logic [IPG_W-1:0]  IPG_RST  = 13'd1;
  localparam logic [MODE_W-1:0] MODE_RST = MODE_COUNT;

  localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  typedef struct packed {
    logic clr_en;
    logic load;
    logic mul_en;
    logic rd_en;
    logic upd_en;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } sts_t;

endpackage

### sv/iga_ctrl.sv
// ---------------------------------------------------------------------------
// iga_ctrl
// Sequencer: table clear after reset, then load, multiply, read, update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iga_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output iga_pkg::cmd_t cmd,
  input  iga_pkg::sts_t sts
);
  import iga_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_READ,
    ST_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
          busy_nxt  = 1'b1;
        end
      end
      ST_MUL:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: begin
        state_nxt     = ST_IDLE;
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.clr_en = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && start;
    cmd.mul_en = (state_r == ST_MUL);
    cmd.rd_en  = (state_r == ST_READ);
    cmd.upd_en = (state_r == ST_UPD);
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `ASSERT_RST(a_valid_idle, clk, rst_n, out_valid |-> !busy, "result while busy")
  `ASSERT_RST(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
  `ASSERT_RST(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "strobe held")
  `ASSERT_RST(a_busy_state, clk, rst_n, busy == (state_r != ST_IDLE), "busy mismatch")

endmodule

### sv/iga_datapath.sv
// ---------------------------------------------------------------------------
// iga_datapath
// Config registers, address and square multipliers, accumulator table and
// saturating update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iga_datapath #(
  parameter int TABLE_DEPTH = iga_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iga_pkg::cmd_t                        cmd,
  output iga_pkg::sts_t                        sts,
  input  logic                                 cfg_we,
  input  logic [iga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iga_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [iga_pkg::GRP_W-1:0]            in_group_id,
  input  logic [iga_pkg::ITV_W-1:0]            in_intervention,
  input  logic signed [iga_pkg::VAL_W-1:0]     in_value,
  output logic signed [iga_pkg::TOT_W-1:0]     out_new_total,
  output logic                                 out_out_of_range,
  output logic                                 out_saturated
);
  import iga_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0]     CLR_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(TABLE_DEPTH);

  logic [TOT_W-1:0] mem [TABLE_DEPTH];

  logic [IPG_W-1:0]  ipg_r;
  logic [MODE_W-1:0] mode_r;

  logic [GRP_W-1:0]  grp_r;
  logic [ITV_W-1:0]  itv_r;
  logic [VAL_W-1:0]  value_r;

  logic [ADDR_W-1:0] prod_r;
  logic [TOT_W-1:0]  sq_r;
  logic              itv_ok_r;

  logic [ADDR_W-1:0] addr_c;
  logic [AW-1:0]     addr_r;
  logic              in_range_r;
  logic [TOT_W-1:0]  rdata_r;

  logic [AW-1:0]     clr_cnt_r;

  logic [VAL_W-1:0]  mag_c;
  logic [TOT_W-1:0]  addend_c;
  logic [TOT_W-1:0]  sum_c;
  logic              ovf_c;
  logic [TOT_W-1:0]  sat_c;

  logic [TOT_W-1:0]  total_r;
  logic              oor_r;
  logic              sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipg_r  <= IPG_RST;
      mode_r <= MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IPG:  ipg_r  <= cfg_wdata[IPG_W-1:0];
        REG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && (clr_cnt_r != CLR_LAST)) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign sts.clr_done = (clr_cnt_r == CLR_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp_r   <= in_group_id;
      itv_r   <= in_intervention;
      value_r <= in_value;
    end
  end

  assign mag_c = value_r[VAL_W-1] ? (VAL_W'(0) - value_r) : value_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r   <= ADDR_W'(grp_r) * ADDR_W'(ipg_r);
      sq_r     <= TOT_W'(mag_c) * TOT_W'(mag_c);
      itv_ok_r <= ({1'b0, itv_r} < ipg_r);
    end
  end

  assign addr_c = prod_r + ADDR_W'(itv_r);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      addr_r     <= addr_c[AW-1:0];
      in_range_r <= itv_ok_r && (addr_c < DEPTH_A);
      rdata_r    <= mem[addr_c[AW-1:0]];
    end
  end

  always_comb begin
    case (mode_r)
      MODE_COUNT: addend_c = TOT_W'(1);
      MODE_SUM:   addend_c = {{(TOT_W-VAL_W){value_r[VAL_W-1]}}, value_r};
      MODE_SQSUM: addend_c = sq_r;
      default:    addend_c = '0;
    endcase
  end

  assign sum_c = rdata_r + addend_c;
  assign ovf_c = (rdata_r[TOT_W-1] ^ sum_c[TOT_W-1]) & (addend_c[TOT_W-1] ^ sum_c[TOT_W-1]);
  assign sat_c = ovf_c ? (rdata_r[TOT_W-1] ? TOT_MIN : TOT_MAX) : sum_c;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.upd_en && in_range_r) begin
      mem[addr_r] <= sat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      total_r <= in_range_r ? sat_c : '0;
      oor_r   <= !in_range_r;
      sat_r   <= in_range_r && ovf_c;
    end
  end

  assign out_new_total    = total_r;
  assign out_out_of_range = oor_r;
  assign out_saturated    = sat_r;

endmodule

### sv/intervention_group_aggregator.sv
// ---------------------------------------------------------------------------
// intervention_group_aggregator
// Grouped scatter-add table: count, sum or sum of squares per cell.
// ---------------------------------------------------------------------------
// After reset, busy stays high while the table is cleared; config
// writes are taken during that time. An item is accepted when start is
// high and busy is low. Its result is driven on the out_ ports with
// out_valid high for exactly one cycle, after the item has passed the
// address and square multiply stage, the registered table read and the
// update write. The receiver cannot stall, so it must capture the result
// in that cycle. The next item may be accepted at the edge that ends the
// result cycle; no item is accepted while another is in flight.
`timescale 1ns / 1ps

module intervention_group_aggregator #(
  parameter int TABLE_DEPTH = iga_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [iga_pkg::GRP_W-1:0]         in_group_id,
  input  logic [iga_pkg::ITV_W-1:0]         in_intervention,
  input  logic signed [iga_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic signed [iga_pkg::TOT_W-1:0]  out_new_total,
  output logic                              out_out_of_range,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [iga_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iga_pkg::CFG_W-1:0]         cfg_wdata
);
  import iga_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  iga_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_group_id      (in_group_id),
    .in_intervention  (in_intervention),
    .in_value         (in_value),
    .out_new_total    (out_new_total),
    .out_out_of_range (out_out_of_range),
    .out_saturated    (out_saturated)
  );

endmodule
